// File: hw/rtl/ngga_pkg.sv
// Shared types, constants and column tables of the GGA sentence parser.
package ngga_pkg;

	localparam int MAX_SENTENCE_LEN_DEF = 80;

	localparam int POS_W     = 7;
	localparam int WEIGHT_W  = 26;
	localparam int PROD_W    = 30;
	localparam int TIME_W    = 29;
	localparam int LAT_ACC_W = 26;
	localparam int LON_ACC_W = 30;
	localparam int LAT_Y_W   = 29;
	localparam int LON_Y_W   = 32;
	localparam int LAT_Q_W   = 27;
	localparam int LAT_W     = 28;
	localparam int LON_W     = 31;

	// floor(y / 3) == (y * RECIP3) >> RECIP3_SHIFT for any y below 2**32
	localparam logic [31:0] RECIP3       = 32'hAAAA_AAAB;
	localparam int          RECIP3_SHIFT = 33;

	localparam logic [7:0] ASCII_NUL    = 8'h00;
	localparam logic [7:0] ASCII_LF     = 8'h0A;
	localparam logic [7:0] ASCII_CR     = 8'h0D;
	localparam logic [7:0] ASCII_DOLLAR = 8'h24;
	localparam logic [7:0] ASCII_COMMA  = 8'h2C;
	localparam logic [7:0] ASCII_DOT    = 8'h2E;
	localparam logic [7:0] ASCII_0      = 8'h30;
	localparam logic [7:0] ASCII_9      = 8'h39;
	localparam logic [7:0] ASCII_E      = 8'h45;
	localparam logic [7:0] ASCII_N      = 8'h4E;
	localparam logic [7:0] ASCII_S      = 8'h53;
	localparam logic [7:0] ASCII_W      = 8'h57;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_FORMAT      = 3'd1,
		ST_LENGTH      = 3'd2,
		ST_UNKNOWN     = 3'd3,
		ST_NOT_DECODED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_GGA  = 2'd1,
		KIND_LSP  = 2'd2
	} kind_t;

	// One finished sentence, before the degree scaling.
	typedef struct packed {
		status_t                status;
		kind_t                  kind;
		logic [TIME_W-1:0]      time_ms;
		logic [LAT_ACC_W-1:0]   lat_sixths;
		logic                   south;
		logic [LON_ACC_W-1:0]   lon_sixths;
		logic                   west;
	} result_t;

	function automatic logic [7:0] gga_char(input logic [POS_W-1:0] p);
		logic [7:0] c;
		case (p)
			7'd1:    c = 8'h47; // G
			7'd2:    c = 8'h50; // P
			7'd3:    c = 8'h47; // G
			7'd4:    c = 8'h47; // G
			7'd5:    c = 8'h41; // A
			default: c = ASCII_COMMA;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] lsp_char(input logic [POS_W-1:0] p);
		logic [7:0] c;
		case (p)
			7'd1:    c = 8'h50; // P
			7'd2:    c = 8'h53; // S
			7'd3:    c = 8'h4C; // L
			7'd4:    c = 8'h53; // S
			7'd5:    c = 8'h50; // P
			default: c = ASCII_COMMA;
		endcase
		return c;
	endfunction

	// Digit weight of a fixed column: time in ms, angles in 1e-4 minutes.
	function automatic logic [WEIGHT_W-1:0] col_weight(input logic [POS_W-1:0] p);
		logic [WEIGHT_W-1:0] w;
		case (p)
			7'd7:    w = 26'd36000000;
			7'd8:    w = 26'd3600000;
			7'd9:    w = 26'd600000;
			7'd10:   w = 26'd60000;
			7'd11:   w = 26'd10000;
			7'd12:   w = 26'd1000;
			7'd14:   w = 26'd100;
			7'd15:   w = 26'd10;
			7'd16:   w = 26'd1;
			7'd18:   w = 26'd6000000;
			7'd19:   w = 26'd600000;
			7'd20:   w = 26'd100000;
			7'd21:   w = 26'd10000;
			7'd23:   w = 26'd1000;
			7'd24:   w = 26'd100;
			7'd25:   w = 26'd10;
			7'd26:   w = 26'd1;
			7'd30:   w = 26'd60000000;
			7'd31:   w = 26'd6000000;
			7'd32:   w = 26'd600000;
			7'd33:   w = 26'd100000;
			7'd34:   w = 26'd10000;
			7'd36:   w = 26'd1000;
			7'd37:   w = 26'd100;
			7'd38:   w = 26'd10;
			7'd39:   w = 26'd1;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

// File: hw/rtl/nmea_gga_sentence_parser_unit.sv
// Top level of the NMEA GGA sentence parser: byte parser plus degree scaling pipeline.
//
// Usage:
//   s_axis carries one sentence byte per transaction: tdata[7:0] is the byte,
//   tuser[0] marks the first byte of a sentence and drops any partial one.
//   m_axis carries one result per sentence ('$' check failure, terminator,
//   NUL, overlength): tuser holds status and kind, tdata holds fix time,
//   latitude and longitude (zero unless status ok and kind GGA).
// Throughput: one byte per cycle while s_axis_tready is high; the parser state
//   is updated in the cycle a byte is accepted, so bytes may follow back to back
//   with no gaps.
// Pipeline: the result of the byte ending its sentence is registered through the
//   parse register, times-five stage, reciprocal multiply by 1/3, then sign and
//   output register, which drives m_axis_tvalid.
// Stalls: each stage loads when empty or when its content moves on, so bytes
//   that produce no result keep flowing while the output waits; s_axis_tready
//   drops only when all four result stages are full and m_axis_tready is low.
// Reset: arst_n clears all valid bits and the parser state; bytes are ignored
//   until a start-marked byte arrives.
module nmea_gga_sentence_parser_unit #(
	parameter int MAX_SENTENCE_LEN = ngga_pkg::MAX_SENTENCE_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] char_byte
	input  logic [0:0]  s_axis_tuser,  // [0] sentence_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [28:0] fix_time_ms, [56:29] latitude_udeg, [87:57] longitude_udeg
	output logic [87:0] m_axis_tdata,
	// [2:0] parse_status, [4:3] sentence_kind
	output logic [4:0]  m_axis_tuser
);

	logic              fire;
	logic              emit;
	ngga_pkg::result_t res;

	// stage valids and load enables
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	ngga_pkg::result_t res_s1;

	ngga_pkg::status_t              st_s2, st_s3, st_s4;
	ngga_pkg::kind_t                kind_s2, kind_s3, kind_s4;
	logic [ngga_pkg::TIME_W-1:0]    time_s2, time_s3, time_s4;
	logic [ngga_pkg::LAT_Y_W-1:0]   laty_s2;
	logic [ngga_pkg::LON_Y_W-1:0]   lony_s2;
	logic                           south_s2, south_s3;
	logic                           west_s2, west_s3;
	logic [ngga_pkg::LAT_Q_W-1:0]   latq_s3;
	logic [ngga_pkg::LON_ACC_W-1:0] lonq_s3;
	logic [ngga_pkg::LAT_W-1:0]     lat_s4;
	logic [ngga_pkg::LON_W-1:0]     lon_s4;

	logic [60:0] lat_prod;
	logic [63:0] lon_prod;

	assign rdy4 = !v_s4 || m_axis_tready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign s_axis_tready = rdy1;
	assign fire          = s_axis_tvalid && rdy1;

	ngga_byte_parse #(
		.MAX_SENTENCE_LEN(MAX_SENTENCE_LEN)
	) u_parse (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (fire),
		.char_byte      (s_axis_tdata),
		.sentence_start (s_axis_tuser[0]),
		.emit           (emit),
		.res            (res)
	);

	// floor(y/3) by reciprocal; y = 5 * sixths fits 32 bits for both angles
	assign lat_prod = 61'(laty_s2) * 61'(ngga_pkg::RECIP3);
	assign lon_prod = 64'(lony_s2) * 64'(ngga_pkg::RECIP3);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= emit;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// payload: advance each stage when it may load
	always_ff @(posedge clk) begin
		if (rdy1) res_s1 <= res;
		if (rdy2) begin
			st_s2    <= res_s1.status;
			kind_s2  <= res_s1.kind;
			time_s2  <= res_s1.time_ms;
			laty_s2  <= {1'b0, res_s1.lat_sixths, 2'b00} + 29'(res_s1.lat_sixths);
			lony_s2  <= {res_s1.lon_sixths, 2'b00} + 32'(res_s1.lon_sixths);
			south_s2 <= res_s1.south;
			west_s2  <= res_s1.west;
		end
		if (rdy3) begin
			st_s3    <= st_s2;
			kind_s3  <= kind_s2;
			time_s3  <= time_s2;
			latq_s3  <= lat_prod[59:ngga_pkg::RECIP3_SHIFT];
			lonq_s3  <= lon_prod[62:ngga_pkg::RECIP3_SHIFT];
			south_s3 <= south_s2;
			west_s3  <= west_s2;
		end
		if (rdy4) begin
			st_s4   <= st_s3;
			kind_s4 <= kind_s3;
			time_s4 <= time_s3;
			// negate the magnitude for south and west
			lat_s4  <= south_s3 ? (ngga_pkg::LAT_W'(0) - ngga_pkg::LAT_W'(latq_s3))
				: ngga_pkg::LAT_W'(latq_s3);
			lon_s4  <= west_s3 ? (ngga_pkg::LON_W'(0) - ngga_pkg::LON_W'(lonq_s3))
				: ngga_pkg::LON_W'(lonq_s3);
		end
	end

	assign m_axis_tvalid = v_s4;
	assign m_axis_tdata  = {lon_s4, lat_s4, time_s4};
	assign m_axis_tuser  = {kind_s4, st_s4};

endmodule

// File: hw/rtl/ngga_byte_parse.sv
// Per-byte sentence state: framing, header match and fixed-column digit accumulation.
module ngga_byte_parse #(
	parameter int MAX_SENTENCE_LEN = ngga_pkg::MAX_SENTENCE_LEN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  logic [7:0]            char_byte,
	input  logic                  sentence_start,
	output logic                  emit,
	output ngga_pkg::result_t     res
);

	localparam logic [ngga_pkg::POS_W-1:0] LAST_POS =
		ngga_pkg::POS_W'(MAX_SENTENCE_LEN - 1);

	logic [ngga_pkg::POS_W-1:0]     pos_q, pos_d;
	logic                           act_q, act_d;
	logic                           cr_q, cr_d;
	logic                           gga_q, gga_d;
	logic                           lsp_q, lsp_d;
	logic                           flt_q, flt_d;
	logic [ngga_pkg::TIME_W-1:0]    tacc_q, tacc_d;
	logic [ngga_pkg::LAT_ACC_W-1:0] lacc_q, lacc_d;
	logic                           south_q, south_d;
	logic [ngga_pkg::LON_ACC_W-1:0] oacc_q, oacc_d;
	logic                           west_q, west_d;
	logic                           emit_c;
	ngga_pkg::status_t              st_c;
	ngga_pkg::kind_t                kind_c;
	logic                           digit_ok;
	logic [ngga_pkg::PROD_W-1:0]    wprod;

	always_comb begin
		pos_d   = pos_q;
		act_d   = act_q;
		cr_d    = cr_q;
		gga_d   = gga_q;
		lsp_d   = lsp_q;
		flt_d   = flt_q;
		tacc_d  = tacc_q;
		lacc_d  = lacc_q;
		south_d = south_q;
		oacc_d  = oacc_q;
		west_d  = west_q;
		emit_c  = 1'b0;
		st_c    = ngga_pkg::ST_OK;
		kind_c  = ngga_pkg::KIND_NONE;

		// a start mark drops any partial sentence
		if (sentence_start) begin
			pos_d   = '0;
			act_d   = 1'b1;
			cr_d    = 1'b0;
			gga_d   = 1'b1;
			lsp_d   = 1'b1;
			flt_d   = 1'b0;
			tacc_d  = '0;
			lacc_d  = '0;
			south_d = 1'b0;
			oacc_d  = '0;
			west_d  = 1'b0;
		end

		digit_ok = (char_byte >= ngga_pkg::ASCII_0) && (char_byte <= ngga_pkg::ASCII_9);
		wprod    = ngga_pkg::PROD_W'(char_byte[3:0]) *
			ngga_pkg::PROD_W'(ngga_pkg::col_weight(pos_d));

		if (act_d) begin
			if (pos_d == '0) begin
				if (char_byte != ngga_pkg::ASCII_DOLLAR) begin
					emit_c = 1'b1;
					st_c   = ngga_pkg::ST_FORMAT;
					act_d  = 1'b0;
				end else begin
					pos_d = ngga_pkg::POS_W'(1);
				end
			end else begin
				if (pos_d <= ngga_pkg::POS_W'(6)) begin
					if (char_byte != ngga_pkg::gga_char(pos_d)) gga_d = 1'b0;
					if (char_byte != ngga_pkg::lsp_char(pos_d)) lsp_d = 1'b0;
				end

				case (pos_d) inside
					[7'd7:7'd12], [7'd14:7'd16]: begin
						if (digit_ok) tacc_d = tacc_d + ngga_pkg::TIME_W'(wprod);
						else flt_d = 1'b1;
					end
					[7'd18:7'd21], [7'd23:7'd26]: begin
						if (digit_ok) lacc_d = lacc_d + ngga_pkg::LAT_ACC_W'(wprod);
						else flt_d = 1'b1;
					end
					[7'd30:7'd34], [7'd36:7'd39]: begin
						if (digit_ok) oacc_d = oacc_d + ngga_pkg::LON_ACC_W'(wprod);
						else flt_d = 1'b1;
					end
					7'd13, 7'd22, 7'd35: begin
						if (char_byte != ngga_pkg::ASCII_DOT) flt_d = 1'b1;
					end
					7'd17, 7'd27, 7'd40: begin
						if (char_byte != ngga_pkg::ASCII_COMMA) flt_d = 1'b1;
					end
					7'd28: begin
						if (char_byte == ngga_pkg::ASCII_S) south_d = 1'b1;
						else if (char_byte != ngga_pkg::ASCII_N) flt_d = 1'b1;
					end
					7'd41: begin
						if (char_byte == ngga_pkg::ASCII_W) west_d = 1'b1;
						else if (char_byte != ngga_pkg::ASCII_E) flt_d = 1'b1;
					end
					default: ;
				endcase

				if (cr_d && (char_byte == ngga_pkg::ASCII_LF)) begin
					emit_c = 1'b1;
					act_d  = 1'b0;
					if (gga_d) begin
						kind_c = ngga_pkg::KIND_GGA;
						st_c   = flt_d ? ngga_pkg::ST_FORMAT : ngga_pkg::ST_OK;
					end else if (lsp_d) begin
						kind_c = ngga_pkg::KIND_LSP;
						st_c   = ngga_pkg::ST_NOT_DECODED;
					end else begin
						st_c = ngga_pkg::ST_UNKNOWN;
					end
				end else if ((char_byte == ngga_pkg::ASCII_NUL) || (pos_d >= LAST_POS)) begin
					emit_c = 1'b1;
					act_d  = 1'b0;
					st_c   = ngga_pkg::ST_LENGTH;
				end else begin
					cr_d  = (char_byte == ngga_pkg::ASCII_CR);
					pos_d = pos_d + ngga_pkg::POS_W'(1);
				end
			end
		end
	end

	always_comb begin
		emit       = fire && emit_c;
		res.status = st_c;
		res.kind   = kind_c;
		// fields stay zero unless this is a clean GGA fix
		if ((st_c == ngga_pkg::ST_OK) && (kind_c == ngga_pkg::KIND_GGA)) begin
			res.time_ms    = tacc_d;
			res.lat_sixths = lacc_d;
			res.south      = south_d;
			res.lon_sixths = oacc_d;
			res.west       = west_d;
		end else begin
			res.time_ms    = '0;
			res.lat_sixths = '0;
			res.south      = 1'b0;
			res.lon_sixths = '0;
			res.west       = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			act_q   <= 1'b0;
			cr_q    <= 1'b0;
			gga_q   <= 1'b0;
			lsp_q   <= 1'b0;
			flt_q   <= 1'b0;
			tacc_q  <= '0;
			lacc_q  <= '0;
			south_q <= 1'b0;
			oacc_q  <= '0;
			west_q  <= 1'b0;
		end else if (fire) begin
			pos_q   <= pos_d;
			act_q   <= act_d;
			cr_q    <= cr_d;
			gga_q   <= gga_d;
			lsp_q   <= lsp_d;
			flt_q   <= flt_d;
			tacc_q  <= tacc_d;
			lacc_q  <= lacc_d;
			south_q <= south_d;
			oacc_q  <= oacc_d;
			west_q  <= west_d;
		end
	end

endmodule
